// ===== src/swsh_pkg.sv =====
// ============================================================================
// Sliding window string hash - shared package
// Field widths, register indexes, reset values and the control and status
// structs passed between the top level and its bit-serial units.
// ============================================================================
package swsh_pkg;

    // Default width of the internal hash and power registers
    localparam int HASH_WIDTH_DEF = 64;

    // Fixed field widths
    localparam int CHAR_W    = 8;
    localparam int RADIX_W   = 8;
    localparam int WLEN_W    = 6;
    localparam int OUT_W     = 63;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CHAR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 2'd2;

    // Configuration reset values
    localparam logic [RADIX_W-1:0] RADIX_RST      = 8'd26;
    localparam logic [CHAR_W-1:0]  FIRST_CHAR_RST = 8'd97;
    localparam logic [WLEN_W-1:0]  WINDOW_LEN_RST = 6'd8;

    // Control for a bit-serial unit: clear its carries or remainder, advance one bit
    typedef struct packed {
        logic clear;
        logic step;
    } t_step_ctl;

    // Status of the multiply-accumulate pass, valid on its last bit
    typedef struct packed {
        logic hash_ovf;   // d*power + hash carried out of the word
        logic power_ovf;  // power*radix carried out of the word
        logic t_zero;     // d*power + hash was zero
    } t_mac_flags;

endpackage

// ===== src/swsh_bit_mac.sv =====
// ============================================================================
// Sliding window string hash - bit-serial multiply-accumulate
// Takes the hash and power words LSB first, one bit per cycle while stepped,
// and produces the bits of hash + d*power, of that sum minus one, and of power*radix.
// ============================================================================
module swsh_bit_mac
    import swsh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_step_ctl          i_ctl,
    input  logic [RADIX_W-1:0] i_digit,
    input  logic [RADIX_W-1:0] i_radix,
    input  logic               i_hash_bit,
    input  logic               i_power_bit,
    output logic               o_sum_bit,
    output logic               o_dec_bit,
    output logic               o_prod_bit,
    output t_mac_flags         o_flags
);

    // Carry of the digit product plus hash never exceeds 256
    logic [8:0] r_c_hash;
    logic [7:0] r_c_power;
    logic       r_borrow;

    logic [9:0] w_s_hash;
    logic [8:0] w_s_power;
    logic [8:0] n_c_hash;
    logic [7:0] n_c_power;
    logic       n_borrow;

    // One bit of each sum
    always_comb begin
        w_s_hash  = 10'(i_digit & {RADIX_W{i_power_bit}}) + 10'(i_hash_bit) + 10'(r_c_hash);
        w_s_power = 9'(i_radix & {RADIX_W{i_power_bit}}) + 9'(r_c_power);
        n_c_hash  = w_s_hash[9:1];
        n_c_power = w_s_power[8:1];
        n_borrow  = r_borrow & ~w_s_hash[0];
    end

    assign o_sum_bit  = w_s_hash[0];
    assign o_dec_bit  = w_s_hash[0] ^ r_borrow;
    assign o_prod_bit = w_s_power[0];

    // Flags as they stand after the current bit
    assign o_flags.hash_ovf  = (n_c_hash != 9'd0);
    assign o_flags.power_ovf = (n_c_power != 8'd0);
    assign o_flags.t_zero    = n_borrow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_c_hash  <= '0;
            r_c_power <= '0;
            r_borrow  <= 1'b1;
        end else if (i_ctl.step) begin
            r_c_hash  <= n_c_hash;
            r_c_power <= n_c_power;
            r_borrow  <= n_borrow;
        end
    end

endmodule

// ===== src/swsh_div.sv =====
// ============================================================================
// Sliding window string hash - restoring divider
// Takes the dividend MSB first, one bit per cycle while stepped, and returns
// one quotient bit per stepped cycle; the divisor is an 8-bit radix.
// ============================================================================
module swsh_div
    import swsh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_step_ctl          i_ctl,
    input  logic [RADIX_W-1:0] i_divisor,
    input  logic               i_dividend_bit,
    output logic               o_quot_bit
);

    logic [RADIX_W-1:0] r_rem;
    logic [RADIX_W:0]   w_trial;
    logic               w_ge;
    logic [RADIX_W-1:0] n_rem;

    // Shift in a bit, subtract when the partial remainder allows
    always_comb begin
        w_trial = {r_rem, i_dividend_bit};
        w_ge    = (w_trial >= {1'b0, i_divisor});
        n_rem   = w_ge ? RADIX_W'(w_trial - {1'b0, i_divisor}) : w_trial[RADIX_W-1:0];
    end

    assign o_quot_bit = w_ge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_rem <= '0;
        end else if (i_ctl.step) begin
            r_rem <= n_rem;
        end
    end

endmodule

// ===== src/sliding_window_string_hash.sv =====
// ============================================================================
// Sliding window string hash - top level
// Bijective base-radix rolling hash over a window of characters.
// ============================================================================
// One character is taken per transaction while the block is idle. A
// character that is still filling the window runs the bit-serial
// multiply-accumulate pass, which walks the hash and power registers one
// bit per cycle, and gives a result only if it completes the window; a
// character that slides the window runs that pass and then the restoring
// divider, which yields one quotient bit per cycle, and gives a result. A
// finished result waits in the output register, and the next character is
// accepted meanwhile.
module sliding_window_string_hash
    import swsh_pkg::*;
#(
    parameter int HASH_WIDTH = HASH_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // character channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [CHAR_W-1:0]    i_char_code,
    input  logic                 i_start_req,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [OUT_W-1:0]     o_window_hash,
    output logic                 o_error_flag,
    // configuration channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int CNT_W = $clog2(HASH_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HASH_WIDTH - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAC  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_WAIT = 2'd3;

    // Configuration
    logic [RADIX_W-1:0]    r_radix;
    logic [CHAR_W-1:0]     r_first_char;
    logic [WLEN_W-1:0]     r_window_len;

    // Hash state
    logic [HASH_WIDTH-1:0] r_hash;
    logic [HASH_WIDTH-1:0] r_power;
    logic [WLEN_W-1:0]     r_seen;
    logic                  r_err;

    // Sequencing
    logic [1:0]            r_state;
    logic [1:0]            n_state;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_fill;
    logic                  r_tzero;
    logic [RADIX_W-1:0]    r_digit;

    // Output register
    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_out_hash;
    logic                  r_out_err;

    logic                  w_accept;
    logic                  w_out_take;
    logic                  w_out_load;
    logic                  w_mac_last;
    logic                  w_div_last;
    logic [RADIX_W-1:0]    w_diff;
    logic [RADIX_W:0]      w_diff_p1;
    logic                  w_digit_ok;
    logic [WLEN_W-1:0]     w_seen_base;
    logic                  w_err_base;
    logic [WLEN_W-1:0]     w_seen_p1;
    logic [RADIX_W-1:0]    w_divisor;
    logic [63:0]           w_hash64;

    t_step_ctl             w_mac_ctl;
    t_step_ctl             w_div_ctl;
    t_mac_flags            w_flags;
    logic                  w_sum_bit;
    logic                  w_dec_bit;
    logic                  w_prod_bit;
    logic                  w_quot_bit;

    assign o_cfg_ready   = 1'b1;
    assign o_in_ready    = (r_state == ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_window_hash = r_out_hash;
    assign o_error_flag  = r_out_err;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_take = r_out_valid && i_out_ready;
    assign w_out_load = (r_state == ST_WAIT) && (!r_out_valid || i_out_ready);
    assign w_mac_last = (r_state == ST_MAC) && (r_cnt == CNT_LAST);
    assign w_div_last = (r_state == ST_DIV) && (r_cnt == CNT_LAST);

    // Digit decode; an out-of-range code counts as digit zero
    always_comb begin
        w_diff      = i_char_code - r_first_char;
        w_diff_p1   = {1'b0, w_diff} + 9'd1;
        w_digit_ok  = (i_char_code >= r_first_char) && (w_diff_p1 <= {1'b0, r_radix});
        w_seen_base = i_start_req ? '0 : r_seen;
        w_err_base  = (i_start_req ? 1'b0 : r_err) | ~w_digit_ok;
    end

    assign w_seen_p1 = r_seen + 6'd1;
    assign w_divisor = (r_radix == '0) ? 8'd1 : r_radix;
    assign w_hash64  = 64'(r_hash);

    // Bit-serial units
    assign w_mac_ctl.clear = w_accept;
    assign w_mac_ctl.step  = (r_state == ST_MAC);
    assign w_div_ctl.clear = w_mac_last && !r_fill;
    assign w_div_ctl.step  = (r_state == ST_DIV);

    swsh_bit_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_mac_ctl),
        .i_digit     (r_digit),
        .i_radix     (r_radix),
        .i_hash_bit  (r_hash[0]),
        .i_power_bit (r_power[0]),
        .o_sum_bit   (w_sum_bit),
        .o_dec_bit   (w_dec_bit),
        .o_prod_bit  (w_prod_bit),
        .o_flags     (w_flags)
    );

    swsh_div u_div (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_div_ctl),
        .i_divisor      (w_divisor),
        .i_dividend_bit (r_hash[HASH_WIDTH-1]),
        .o_quot_bit     (w_quot_bit)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix      <= RADIX_RST;
            r_first_char <= FIRST_CHAR_RST;
            r_window_len <= WINDOW_LEN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_RADIX:      r_radix      <= i_cfg_data;
                CFG_FIRST_CHAR: r_first_char <= i_cfg_data;
                CFG_WINDOW_LEN: r_window_len <= i_cfg_data[WLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_MAC;
            end
            ST_MAC: begin
                if (w_mac_last) begin
                    if (!r_fill)                        n_state = ST_DIV;
                    else if (w_seen_p1 == r_window_len) n_state = ST_WAIT;
                    else                                n_state = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (w_div_last) n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (w_out_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept || w_mac_last || w_div_last) r_cnt <= '0;
            else if (r_state == ST_MAC || r_state == ST_DIV) r_cnt <= r_cnt + 1'b1;
        end
    end

    // Hash datapath: load on accept, shift right while accumulating,
    // shift left while dividing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash  <= '0;
            r_power <= HASH_WIDTH'(1);
            r_seen  <= '0;
            r_err   <= 1'b0;
            r_fill  <= 1'b0;
            r_tzero <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (i_start_req) begin
                            r_hash  <= '0;
                            r_power <= HASH_WIDTH'(1);
                        end
                        r_seen  <= w_seen_base;
                        r_err   <= w_err_base;
                        r_fill  <= (w_seen_base < r_window_len);
                        r_digit <= w_digit_ok ? w_diff_p1[RADIX_W-1:0] : '0;
                    end
                end
                ST_MAC: begin
                    if (r_fill) begin
                        r_hash  <= {w_sum_bit, r_hash[HASH_WIDTH-1:1]};
                        r_power <= {w_prod_bit, r_power[HASH_WIDTH-1:1]};
                    end else begin
                        r_hash  <= {w_dec_bit, r_hash[HASH_WIDTH-1:1]};
                        r_power <= {r_power[0], r_power[HASH_WIDTH-1:1]};
                    end
                    if (w_mac_last) begin
                        if (r_fill) begin
                            r_seen <= w_seen_p1;
                            r_err  <= r_err | w_flags.hash_ovf | w_flags.power_ovf;
                        end else begin
                            r_err   <= r_err | w_flags.hash_ovf;
                            r_tzero <= w_flags.t_zero;
                        end
                    end
                end
                ST_DIV: begin
                    r_hash <= r_tzero ? '0 : {r_hash[HASH_WIDTH-2:0], w_quot_bit};
                end
                ST_WAIT: begin
                    if (w_out_load) r_err <= r_err | w_hash64[63];
                end
                default: ;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_hash <= w_hash64[OUT_W-1:0];
            r_out_err  <= r_err | w_hash64[63];
        end
    end

`ifndef SYNTHESIS
    // An accepted character always starts the accumulate pass
    a_accept_to_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_MAC))
        else $error("accepted character did not start accumulation");

    // Division only ever runs for a sliding character
    a_div_only_slide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> !r_fill)
        else $error("divider running during window fill");

    // A result waiting with a free output slot is presented next cycle
    a_wait_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_WAIT) && !r_out_valid) |=> (r_out_valid && (r_state == ST_IDLE)))
        else $error("pending result not moved to output register");

    // The bit counter is idle at zero outside the serial passes
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_IDLE) || (r_state == ST_WAIT)) |-> (r_cnt == '0))
        else $error("bit counter not cleared between passes");
`endif

endmodule
